>>> rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg - shared types and constants of the bounded shifting list
// Command and status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package bsl_pkg;

    // fixed field widths
    localparam int CMD_W    = 4;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT_AT    = 4'd0,
        CMD_INSERT_FRONT = 4'd1,
        CMD_APPEND       = 4'd2,
        CMD_REMOVE_AT    = 4'd3,
        CMD_REMOVE_FRONT = 4'd4,
        CMD_REMOVE_BACK  = 4'd5,
        CMD_READ_AT      = 4'd6,
        CMD_READ_FRONT   = 4'd7,
        CMD_READ_BACK    = 4'd8,
        CMD_CLEAR        = 4'd9
    } bsl_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2
    } bsl_status_t;

    // what the accepted command does to the store
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_READ,
        KIND_INSERT,
        KIND_REMOVE
    } bsl_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_FILL,
        S_RESP
    } bsl_state_t;

endpackage

>>> rtl/bsl_store.sv
// ----------------------------------------------------------------------------
// bsl_store - entry storage of the bounded shifting list
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsl_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next enabled read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bounded_shifting_list_top.sv
// ----------------------------------------------------------------------------
// bounded_shifting_list_top - ordered list of up to CAPACITY entries
// Insert, remove, read and clear on a list kept in positions 0..count-1.
// ----------------------------------------------------------------------------
//  channel | dir | ports                        | contents
//  s_      | in  | s_tvalid s_tready s_tdata    | one command transaction
//  m_      | out | m_tvalid m_tready m_tdata    | one result transaction
//
//  Reads, clear and rejected commands go from acceptance through S_RESP to
//  the output register. Insert steps S_SHIFT, S_DRAIN, S_FILL, S_RESP, remove
//  S_SHIFT, S_DRAIN, S_RESP, both skipping S_SHIFT and S_DRAIN when nothing
//  moves; one entry moves per cycle through the single store port pair.
//  s_tready is high only while the sequencer idles.
//  A result waits in the output register; a stalled m_ side holds the
//  sequencer once the next result is ready. aresetn clears count and control.
// ----------------------------------------------------------------------------
module bounded_shifting_list_top
    import bsl_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // cmd[3:0], position[8:4], entry_value[40:9], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status[1:0], read_value[33:2], entry_count[38:34], is_empty[39],
    // is_full[40], zero fill
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    bsl_state_t state_reg, state_next;

    logic [CNT_W-1:0]       count_reg, count_next;
    bsl_status_t            status_reg, status_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   up_reg, up_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [AW-1:0]          end_reg, end_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [AW-1:0]          waddr_reg, waddr_next;
    logic                   wpend_reg, wpend_next;
    logic [ENTRY_WIDTH-1:0] val_reg, val_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    // decode of the incoming command
    bsl_cmd_t         in_cmd;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    logic [63:0]      in_val_wide;
    bsl_status_t      dec_status;
    bsl_kind_t        dec_kind;
    logic [CNT_W-1:0] dec_count;
    logic [CNT_W-1:0] dec_pos;
    logic [CNT_W-1:0] dec_top;
    logic [CNT_W-1:0] last_idx;
    logic             is_full_now;
    logic             is_empty_now;

    logic             accept;
    logic             out_free;

    // store ports
    logic                   st_wr_en;
    logic [AW-1:0]          st_wr_addr;
    logic [ENTRY_WIDTH-1:0] st_wr_data;
    logic                   st_rd_en;
    logic [AW-1:0]          st_rd_addr;
    logic [ENTRY_WIDTH-1:0] st_rd_data;
    logic [63:0]            rd_wide;
    logic [VAL_W-1:0]       res_value;

    assign in_cmd      = bsl_cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_pos      = s_tdata[CMD_W+POS_W-1:CMD_W];
    assign in_val      = s_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W];
    assign in_val_wide = 64'(in_val);

    assign is_full_now  = (count_reg == CAP_C);
    assign is_empty_now = (count_reg == '0);
    assign last_idx     = CNT_W'(count_reg - CNT_W'(1));

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // command decode against the current count
    always_comb begin
        dec_status = STAT_OK;
        dec_kind   = KIND_NONE;
        dec_count  = count_reg;
        dec_pos    = '0;
        dec_top    = count_reg;
        unique case (in_cmd)
            CMD_INSERT_AT: begin
                dec_pos = in_pos;
                if (in_pos > count_reg) begin
                    dec_status = STAT_INVALID;
                end else if (is_full_now) begin
                    dec_status = STAT_FULL;
                end else begin
                    dec_kind  = KIND_INSERT;
                    dec_count = CNT_W'(count_reg + CNT_W'(1));
                end
            end
            CMD_INSERT_FRONT: begin
                // a full list drops its back entry first
                dec_kind = KIND_INSERT;
                if (is_full_now) begin
                    dec_top = last_idx;
                end else begin
                    dec_count = CNT_W'(count_reg + CNT_W'(1));
                end
            end
            CMD_APPEND: begin
                dec_pos = count_reg;
                if (is_full_now) begin
                    dec_status = STAT_FULL;
                end else begin
                    dec_kind  = KIND_INSERT;
                    dec_count = CNT_W'(count_reg + CNT_W'(1));
                end
            end
            CMD_REMOVE_AT: begin
                dec_pos = in_pos;
                if (in_pos >= count_reg) begin
                    dec_status = STAT_INVALID;
                end else begin
                    dec_kind  = KIND_REMOVE;
                    dec_count = last_idx;
                end
            end
            CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
                dec_pos = (in_cmd == CMD_REMOVE_BACK) ? last_idx : '0;
                if (is_empty_now) begin
                    dec_status = STAT_INVALID;
                end else begin
                    dec_kind  = KIND_REMOVE;
                    dec_count = last_idx;
                end
            end
            CMD_READ_AT: begin
                dec_pos = in_pos;
                if (in_pos >= count_reg) begin
                    dec_status = STAT_INVALID;
                end else begin
                    dec_kind = KIND_READ;
                end
            end
            CMD_READ_FRONT, CMD_READ_BACK: begin
                dec_pos = (in_cmd == CMD_READ_BACK) ? last_idx : '0;
                if (is_empty_now) begin
                    dec_status = STAT_INVALID;
                end else begin
                    dec_kind = KIND_READ;
                end
            end
            CMD_CLEAR: begin
                dec_count = '0;
            end
            default: begin
                dec_status = STAT_INVALID;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (dec_kind == KIND_INSERT) begin
                        state_next = (dec_top == dec_pos) ? S_FILL : S_SHIFT;
                    end else if (dec_kind == KIND_REMOVE) begin
                        state_next = (dec_pos == last_idx) ? S_RESP : S_SHIFT;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SHIFT: begin
                if (ptr_reg == end_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = up_reg ? S_FILL : S_RESP;
            end
            S_FILL: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs: handshake and store port control
    always_comb begin
        s_tready   = 1'b0;
        st_rd_en   = 1'b0;
        st_rd_addr = ptr_reg;
        st_wr_en   = wpend_reg;
        st_wr_addr = waddr_reg;
        st_wr_data = st_rd_data;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                st_rd_en   = accept && (dec_kind == KIND_READ);
                st_rd_addr = dec_pos[AW-1:0];
            end
            S_SHIFT: begin
                st_rd_en = 1'b1;
            end
            S_FILL: begin
                st_wr_en   = 1'b1;
                st_wr_addr = pos_reg;
                st_wr_data = val_reg;
            end
            S_DRAIN, S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // read result, widened or cut to the result field
    assign rd_wide   = 64'(st_rd_data);
    assign res_value = rd_ok_reg ? rd_wide[VAL_W-1:0] : '0;

    // datapath next values
    always_comb begin
        count_next    = count_reg;
        status_next   = status_reg;
        rd_ok_next    = rd_ok_reg;
        up_next       = up_reg;
        ptr_next      = ptr_reg;
        end_next      = end_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        waddr_next    = waddr_reg;
        wpend_next    = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (state_reg == S_IDLE && accept) begin
            count_next  = dec_count;
            status_next = dec_status;
            rd_ok_next  = (dec_kind == KIND_READ);
            up_next     = (dec_kind == KIND_INSERT);
            pos_next    = dec_pos[AW-1:0];
            val_next    = in_val_wide[ENTRY_WIDTH-1:0];
            if (dec_kind == KIND_INSERT) begin
                // move entries top-1 down to pos, each one place up
                ptr_next = AW'(dec_top - CNT_W'(1));
                end_next = dec_pos[AW-1:0];
            end else begin
                // move entries pos+1 up to last, each one place down
                ptr_next = AW'(dec_pos + CNT_W'(1));
                end_next = last_idx[AW-1:0];
            end
        end

        // one entry read per cycle, written back next cycle
        if (state_reg == S_SHIFT) begin
            wpend_next = 1'b1;
            waddr_next = up_reg ? AW'(ptr_reg + AW'(1)) : AW'(ptr_reg - AW'(1));
            ptr_next   = up_reg ? AW'(ptr_reg - AW'(1)) : AW'(ptr_reg + AW'(1));
        end

        // output register load
        if (state_reg == S_RESP && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_DATA_W'({(count_reg == CAP_C), (count_reg == '0),
                                       count_reg, res_value, status_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            wpend_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wpend_reg    <= wpend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        rd_ok_reg   <= rd_ok_next;
        up_reg      <= up_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        waddr_reg   <= waddr_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    bsl_store #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_WIDTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

endmodule

>>> rtl/bsl_checker.sv
// ----------------------------------------------------------------------------
// bsl_checker - port-level checks of the bounded shifting list
// Result consistency and sequencing seen on the top-level ports.
// ----------------------------------------------------------------------------
module bsl_checker
    import bsl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [STAT_W-1:0] r_status;
    logic [VAL_W-1:0]  r_value;
    logic [CNT_W-1:0]  r_count;
    logic              r_empty;
    logic              r_full;
    logic              s_unused;

    assign r_status = m_tdata[1:0];
    assign r_value  = m_tdata[33:2];
    assign r_count  = m_tdata[38:34];
    assign r_empty  = m_tdata[39];
    assign r_full   = m_tdata[40];
    assign s_unused = ^s_tdata;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one command at a time: the sequencer is busy after each transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while busy");

    // flags agree with the count, count within capacity
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r_empty == (r_count == '0)) && (r_full == (r_count == CAP_C))
                     && (r_count <= CAP_C))
        else $error("inconsistent count flags");

    // failed commands return no data and a defined status
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (r_status != STAT_OK) |->
            (r_value == '0) && ((r_status == STAT_INVALID) || (r_status == STAT_FULL)))
        else $error("bad status or data on failure");

    // an idle input side with nothing pending shows no spurious result
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !m_tvalid && !s_unused && !s_tvalid |=> !m_tvalid)
        else $error("result without a command");

endmodule

bind bounded_shifting_list_top bsl_checker #(
    .CAPACITY (CAPACITY)
) u_bsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/bsl_list_checker.sv
// ----------------------------------------------------------------------------
// bsl_list_checker - result checker for the bounded shifting list
// Watches both channels, keeps a shadow copy of the list, predicts the result
// of every accepted command transaction and compares each result transaction
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bsl_list_checker
    import bsl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // cmd[3:0], position[8:4], entry_value[40:9], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // status[1:0], read_value[33:2], entry_count[38:34], is_empty[39],
    // is_full[40], zero fill
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatch_count,
    output int                  results_pending,
    output int                  results_checked
);

    // highest field first, so the layout matches m_tdata[40:0]
    typedef struct packed {
        logic              is_full;
        logic              is_empty;
        logic [CNT_W-1:0]  entry_count;
        logic [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0] status;
    } list_result_t;

    // shadow of the list contents
    logic [VAL_W-1:0] shadow_entries [CAPACITY];
    int               shadow_len;

    // predicted results, oldest first
    list_result_t     expected_results [$];

    // insert with the range test ahead of the full test
    function automatic bsl_status_t shadow_insert(input int pos, input logic [VAL_W-1:0] val);
        if (pos < 0 || pos > shadow_len)
            return STAT_INVALID;
        if (shadow_len >= CAPACITY)
            return STAT_FULL;
        for (int i = shadow_len; i > pos; i--)
            shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[pos] = val;
        shadow_len++;
        return STAT_OK;
    endfunction

    function automatic bsl_status_t shadow_remove(input int pos);
        if (pos < 0 || pos >= shadow_len)
            return STAT_INVALID;
        for (int i = pos; i + 1 < shadow_len; i++)
            shadow_entries[i] = shadow_entries[i+1];
        shadow_len--;
        return STAT_OK;
    endfunction

    function automatic bsl_status_t shadow_read(input int pos, output logic [VAL_W-1:0] val);
        val = '0;
        if (pos < 0 || pos >= shadow_len)
            return STAT_INVALID;
        val = shadow_entries[pos];
        return STAT_OK;
    endfunction

    // apply one command to the shadow list and build its result
    function automatic list_result_t predict_list_cmd(input logic [CMD_W-1:0] cmd,
                                                      input int pos,
                                                      input logic [VAL_W-1:0] val);
        list_result_t res;
        bsl_status_t  st;
        logic [VAL_W-1:0] rd;
        rd = '0;
        case (cmd)
            CMD_INSERT_AT:    st = shadow_insert(pos, val);
            CMD_INSERT_FRONT: begin
                // full list: the back entry makes room
                if (shadow_len >= CAPACITY)
                    void'(shadow_remove(shadow_len - 1));
                st = shadow_insert(0, val);
            end
            CMD_APPEND:       st = shadow_insert(shadow_len, val);
            CMD_REMOVE_AT:    st = shadow_remove(pos);
            CMD_REMOVE_FRONT: st = shadow_remove(0);
            CMD_REMOVE_BACK:  st = shadow_remove(shadow_len - 1);
            CMD_READ_AT:      st = shadow_read(pos, rd);
            CMD_READ_FRONT:   st = shadow_read(0, rd);
            CMD_READ_BACK:    st = shadow_read(shadow_len - 1, rd);
            CMD_CLEAR: begin
                shadow_len = 0;
                st = STAT_OK;
            end
            default:          st = STAT_INVALID;
        endcase
        if (st != STAT_OK)
            rd = '0;
        res.status      = st;
        res.read_value  = rd;
        res.entry_count = CNT_W'(shadow_len);
        res.is_empty    = (shadow_len == 0);
        res.is_full     = (shadow_len == CAPACITY);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // channel monitor: pop on a result transaction, push on a command one
    always @(posedge aclk) begin
        list_result_t want;
        list_result_t seen;
        if (!aresetn) begin
            shadow_len = 0;
            expected_results.delete();
            mismatch_count  = 0;
            results_pending = 0;
            results_checked = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                seen = m_tdata[40:0];
                if (expected_results.size() == 0) begin
                    $error("result transaction with no prediction waiting: 0x%0h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", VAL_W'(want.status), VAL_W'(seen.status));
                    check_field("read_value", want.read_value, seen.read_value);
                    check_field("entry_count", VAL_W'(want.entry_count),
                                VAL_W'(seen.entry_count));
                    check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(seen.is_empty));
                    check_field("is_full", VAL_W'(want.is_full), VAL_W'(seen.is_full));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_list_cmd(s_tdata[3:0], int'(s_tdata[8:4]),
                                                            s_tdata[40:9]));
            results_pending = expected_results.size();
        end
    end

endmodule

>>> sim/tb_bounded_shifting_list_top.sv
// ----------------------------------------------------------------------------
// tb_bounded_shifting_list_top - testbench of the bounded shifting list
// Directed commands on empty, partly filled and full lists, then biased
// random command streams that grow, shrink and churn the list, with random
// idling on both channels, a long result stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_bounded_shifting_list_top
    import bsl_pkg::*;
();

    localparam int CAPACITY      = 16;
    localparam int RANDOM_ITEMS  = 1520;
    localparam int QUIET_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 60;

    // command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd10;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;

    int mismatch_count;
    int results_pending;
    int results_checked;

    bit quiet_phase  = 1'b0;
    bit hold_request = 1'b0;

    int inserts_sent = 0;
    int removes_sent = 0;
    int reads_sent   = 0;
    int others_sent  = 0;

    // 10 time unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bounded_shifting_list_top #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (VAL_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bsl_list_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    // watchdog
    initial begin
        #4_000_000;
        $display("tb_bounded_shifting_list_top: FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int hold_count;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge aclk);
                hold_request = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // offer one command transaction and hold it until accepted
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        s_tdata  <= {{(S_DATA_W-CMD_W-POS_W-VAL_W){1'b0}}, val, pos, cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd <= CMD_APPEND)
            inserts_sent++;
        else if (cmd <= CMD_REMOVE_BACK)
            removes_sent++;
        else if (cmd <= CMD_READ_BACK)
            reads_sent++;
        else
            others_sent++;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // stop offering until every predicted result has been seen
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // reset, directed commands, random commands, verdict
    initial begin
        int n;
        int phase;
        int pick;
        int ins_pct;
        int rem_pct;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;

        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: removes, reads and an insert past the end are rejected
        send_cmd(CMD_READ_FRONT, 5'd0, 32'h0);
        send_cmd(CMD_REMOVE_BACK, 5'd0, 32'h0);
        send_cmd(CMD_REMOVE_FRONT, 5'd0, 32'h0);
        send_cmd(CMD_READ_BACK, 5'd0, 32'h0);
        send_cmd(CMD_REMOVE_AT, 5'd0, 32'h0);
        send_cmd(CMD_READ_AT, 5'd31, 32'h0);
        send_cmd(CMD_INSERT_AT, 5'd1, 32'hDEAD_BEEF);

        // first entries: at index 0, at the back, at the front, at the tail index
        send_cmd(CMD_INSERT_AT, 5'd0, 32'h0000_0000);
        send_cmd(CMD_APPEND, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT_FRONT, 5'd31, 32'hA5A5_5A5A);
        send_cmd(CMD_INSERT_AT, 5'd3, 32'h5A5A_A5A5);
        send_cmd(CMD_READ_AT, 5'd1, 32'h0);
        send_cmd(CMD_READ_BACK, 5'd0, 32'h0);
        send_cmd(CMD_REMOVE_AT, 5'd1, 32'h0);

        // fill to capacity
        for (n = 0; n < CAPACITY - 3; n++)
            send_cmd(CMD_APPEND, 5'd0, $urandom);

        // full list: range test before full test, front insert drops the back
        send_cmd(CMD_APPEND, 5'd0, 32'h1111_1111);
        send_cmd(CMD_INSERT_AT, 5'd17, 32'h2222_2222);
        send_cmd(CMD_INSERT_AT, 5'd16, 32'h3333_3333);
        send_cmd(CMD_INSERT_FRONT, 5'd0, 32'h1234_5678);
        send_cmd(CMD_READ_AT, 5'd15, 32'h0);
        send_cmd(CMD_READ_AT, 5'd16, 32'h0);
        send_cmd(CMD_REMOVE_AT, 5'd15, 32'h0);

        // undefined codes, then clear
        send_cmd(CMD_UNUSED_FIRST, 5'd0, 32'h0);
        send_cmd(CMD_UNUSED_LAST, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_CLEAR, 5'd0, 32'h0);
        send_cmd(CMD_READ_FRONT, 5'd0, 32'h0);

        wait_all_results();

        // random part: phases that grow, shrink and churn the list
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_phase = 1'b1;
            if (n == 400)
                hold_request = 1'b1;
            if (n == 800)
                wait_all_results();

            phase = (n / PHASE_ITEMS) % 3;
            case (phase)
                0: begin
                    ins_pct = 70;
                    rem_pct = 10;
                end
                1: begin
                    ins_pct = 15;
                    rem_pct = 65;
                end
                default: begin
                    ins_pct = 40;
                    rem_pct = 30;
                end
            endcase

            pick = $urandom_range(0, 99);
            if (pick < ins_pct)
                cmd = CMD_W'(CMD_INSERT_AT + $urandom_range(0, 2));
            else if (pick < ins_pct + rem_pct)
                cmd = CMD_W'(CMD_REMOVE_AT + $urandom_range(0, 2));
            else if (pick < 98)
                cmd = CMD_W'(CMD_READ_AT + $urandom_range(0, 2));
            else if (pick == 98)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));

            // mostly indexes near the live range, sometimes anything
            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom_range(0, 31));
            else
                pos = POS_W'($urandom_range(0, CAPACITY + 1));

            case ($urandom_range(0, 9))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom;
            endcase

            send_cmd(cmd, pos, val);
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d commands: %0d inserts, %0d removes, %0d reads,",
                 inserts_sent + removes_sent + reads_sent + others_sent,
                 inserts_sent, removes_sent, reads_sent);
        $display("  %0d clears or undefined codes; %0d results checked, %0d mismatches",
                 others_sent, results_checked, mismatch_count);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("tb_bounded_shifting_list_top: PASS");
        end else begin
            $display("tb_bounded_shifting_list_top: FAIL");
        end
        $finish;
    end

endmodule
